// File: src/kmst_pkg.sv
// ============================================================================
// kmst_pkg - shared types and constants
// Field widths, register map and the controller/datapath command bus.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package kmst_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    localparam int VERTEX_W = 6;
    localparam int WEIGHT_W = 32;
    localparam int INDEX_W  = 8;
    localparam int VCOUNT_W = 7;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_INS,
        OP_INS_CMP,
        OP_INS_WR,
        OP_INIT,
        OP_K_RD,
        OP_K_GET,
        OP_K_LA,
        OP_K_LB,
        OP_WALK,
        OP_EMIT,
        OP_E_RD,
        OP_E_LD
    } kmst_op_t;

    typedef struct packed {
        kmst_op_t op;
    } kmst_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_bad;
        logic in_last;
        logic last_pend;
        logic j_zero;
        logic j_one;
        logic shift;
        logic init_done;
        logic i_done;
        logic range_bad;
        logic same_label;
        logic walk_done;
        logic taken_zero;
        logic out_free;
        logic last_out;
    } kmst_status_t;

endpackage

`default_nettype wire

// File: src/kmst_if.sv
// ============================================================================
// kmst_if - edge and tree channels
// Valid/ready channels carrying one loaded edge or one tree result word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface kmst_in_if;
    import kmst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [VERTEX_W-1:0]        edge_start;
    logic [VERTEX_W-1:0]        edge_end;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       last_edge;

    modport source (output valid, edge_start, edge_end, edge_weight, last_edge, input ready);
    modport sink   (input valid, edge_start, edge_end, edge_weight, last_edge, output ready);
endinterface

interface kmst_out_if;
    import kmst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [INDEX_W-1:0]         tree_edge_index;
    logic [VERTEX_W-1:0]        tree_start;
    logic [VERTEX_W-1:0]        tree_end;
    logic signed [WEIGHT_W-1:0] tree_weight;
    logic                       last_result;
    logic                       no_edge;
    logic                       edges_dropped;

    modport source (output valid, tree_edge_index, tree_start, tree_end, tree_weight,
                    last_result, no_edge, edges_dropped, input ready);
    modport sink   (input valid, tree_edge_index, tree_start, tree_end, tree_weight,
                    last_result, no_edge, edges_dropped, output ready);
endinterface

`default_nettype wire

// File: src/kmst_ram.sv
// ============================================================================
// kmst_ram - generic simple dual-port ram
// One write port, one read port, registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/kmst_ctrl.sv
// ============================================================================
// kmst_ctrl - sequencing state machine
// Steps through load/insert, label init, kruskal scan, relabel walk and emit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kmst_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire kmst_pkg::kmst_status_t status,
    output kmst_pkg::kmst_cmd_t         cmd
);
    import kmst_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_INS, S_INS_CMP, S_INS_WR, S_INIT, S_K_RD, S_K_GET,
        S_K_LA, S_K_LB, S_WALK, S_EMIT, S_E_RD, S_E_LD
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (status.in_fire)
                begin
                    if (!status.in_bad)
                        state_next = S_INS;
                    else if (status.in_last)
                        state_next = S_INIT;
                end
            end
            S_INS:      state_next = status.j_zero ? S_INS_WR : S_INS_CMP;
            S_INS_CMP:
            begin
                if (!status.shift || status.j_one)
                    state_next = S_INS_WR;
            end
            S_INS_WR:   state_next = status.last_pend ? S_INIT : S_LOAD;
            S_INIT:
            begin
                if (status.init_done)
                    state_next = S_K_RD;
            end
            S_K_RD:     state_next = status.i_done ? S_EMIT : S_K_GET;
            S_K_GET:    state_next = status.range_bad ? S_K_RD : S_K_LA;
            S_K_LA:     state_next = S_K_LB;
            S_K_LB:     state_next = status.same_label ? S_K_RD : S_WALK;
            S_WALK:
            begin
                if (status.walk_done)
                    state_next = S_K_RD;
            end
            S_EMIT:
            begin
                if (!status.taken_zero)
                    state_next = S_E_RD;
                else if (status.out_free)
                    state_next = S_LOAD;
            end
            S_E_RD:
            begin
                if (status.out_free)
                    state_next = S_E_LD;
            end
            S_E_LD:     state_next = status.last_out ? S_LOAD : S_E_RD;
            default:    state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_LOAD:    cmd.op = OP_LOAD;
            S_INS:     cmd.op = OP_INS;
            S_INS_CMP: cmd.op = OP_INS_CMP;
            S_INS_WR:  cmd.op = OP_INS_WR;
            S_INIT:    cmd.op = OP_INIT;
            S_K_RD:    cmd.op = OP_K_RD;
            S_K_GET:   cmd.op = OP_K_GET;
            S_K_LA:    cmd.op = OP_K_LA;
            S_K_LB:    cmd.op = OP_K_LB;
            S_WALK:    cmd.op = OP_WALK;
            S_EMIT:    cmd.op = OP_EMIT;
            S_E_RD:    cmd.op = OP_E_RD;
            S_E_LD:    cmd.op = OP_E_LD;
            default:   cmd.op = OP_LOAD;
        endcase
    end

endmodule

`default_nettype wire

// File: src/kmst_dp.sv
// ============================================================================
// kmst_dp - datapath
// Sorted edge list, component labels, taken list, counters, apb register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kmst_dp #(
    parameter int MAX_VERTICES = kmst_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = kmst_pkg::MAX_EDGES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    kmst_in_if.sink                                in_ch,
    kmst_out_if.source                             out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kmst_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [kmst_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [kmst_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire kmst_pkg::kmst_cmd_t               cmd,
    output kmst_pkg::kmst_status_t                 status
);
    import kmst_pkg::*;

    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic [EIDX_W-1:0]          slot;
        logic [VERTEX_W-1:0]        vs;
        logic [VERTEX_W-1:0]        ve;
        logic signed [WEIGHT_W-1:0] w;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    // apb register
    logic [VCOUNT_W-1:0] vc_reg;
    logic                wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == ADDR_VERTEX_COUNT[2]);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_VERTEX_COUNT[2])
            prdata = APB_DATA_W'(vc_reg);
    end

    // effective vertex count
    logic [VCNT_W-1:0] nv;

    always_comb
    begin
        if (32'(vc_reg) > 32'(MAX_VERTICES))
            nv = VCNT_W'(MAX_VERTICES);
        else
            nv = VCNT_W'(vc_reg);
    end

    // state
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              drop_reg, drop_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              lastp_reg, lastp_next;
    entry_t            new_reg, new_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    entry_t            cur_reg, cur_next;
    logic [VID_W-1:0]  la_reg, la_next;
    logic [VID_W-1:0]  lb_reg, lb_next;
    logic [VCNT_W-1:0] v_reg, v_next;
    logic              pend_reg, pend_next;
    logic [VID_W-1:0]  pv_reg, pv_next;
    logic [VCNT_W-1:0] taken_reg, taken_next;
    logic [VCNT_W-1:0] k_reg, k_next;

    logic                       ov_reg, ov_next;
    logic [INDEX_W-1:0]         o_idx_reg, o_idx_next;
    logic [VERTEX_W-1:0]        o_s_reg, o_s_next;
    logic [VERTEX_W-1:0]        o_e_reg, o_e_next;
    logic signed [WEIGHT_W-1:0] o_w_reg, o_w_next;
    logic                       o_last_reg, o_last_next;
    logic                       o_none_reg, o_none_next;
    logic                       o_drop_reg, o_drop_next;

    // memories
    logic              s_we;
    logic [EIDX_W-1:0] s_waddr, s_raddr;
    entry_t            s_wdata, s_rdata;
    logic              l_we;
    logic [VID_W-1:0]  l_waddr, l_raddr, l_wdata, l_rdata;
    logic              r_we;
    logic [VID_W-1:0]  r_waddr, r_raddr;
    entry_t            r_wdata, r_rdata;

    kmst_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EDGES)) u_sorted (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    kmst_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES)) u_label (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    kmst_ram #(.WIDTH(ENT_W), .DEPTH(MAX_VERTICES)) u_taken (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    // status
    logic in_ready;
    logic in_fire;
    logic out_free;

    assign in_ready = (cmd.op == OP_LOAD);
    assign in_fire  = in_ch.valid && in_ready;
    assign out_free = !ov_reg || out_ch.ready;

    always_comb
    begin
        status.in_fire    = in_fire;
        status.in_bad     = (32'(in_ch.edge_start) >= 32'(nv)) ||
                            (32'(in_ch.edge_end) >= 32'(nv)) ||
                            (32'(cnt_reg) == 32'(MAX_EDGES));
        status.in_last    = in_ch.last_edge;
        status.last_pend  = lastp_reg;
        status.j_zero     = (j_reg == '0);
        status.j_one      = (j_reg == CNT_W'(1));
        status.shift      = (s_rdata.w > new_reg.w);
        status.init_done  = (v_reg == VCNT_W'(MAX_VERTICES - 1));
        status.i_done     = (i_reg == cnt_reg);
        status.range_bad  = (32'(s_rdata.vs) >= 32'(nv)) || (32'(s_rdata.ve) >= 32'(nv));
        status.same_label = (la_reg == l_rdata);
        status.walk_done  = (v_reg == nv) && !pend_reg;
        status.taken_zero = (taken_reg == '0);
        status.out_free   = out_free;
        status.last_out   = (k_reg == taken_reg - VCNT_W'(1));
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        j_next      = j_reg;
        lastp_next  = lastp_reg;
        new_next    = new_reg;
        i_next      = i_reg;
        cur_next    = cur_reg;
        la_next     = la_reg;
        lb_next     = lb_reg;
        v_next      = '0;
        pend_next   = 1'b0;
        pv_next     = pv_reg;
        taken_next  = taken_reg;
        k_next      = k_reg;

        ov_next     = ov_reg && !out_ch.ready;
        o_idx_next  = o_idx_reg;
        o_s_next    = o_s_reg;
        o_e_next    = o_e_reg;
        o_w_next    = o_w_reg;
        o_last_next = o_last_reg;
        o_none_next = o_none_reg;
        o_drop_next = o_drop_reg;

        s_we    = 1'b0;
        s_waddr = EIDX_W'(j_reg);
        s_wdata = new_reg;
        s_raddr = EIDX_W'(j_reg - CNT_W'(1));
        l_we    = 1'b0;
        l_waddr = VID_W'(v_reg);
        l_wdata = VID_W'(v_reg);
        l_raddr = VID_W'(cur_reg.vs);
        r_we    = 1'b0;
        r_waddr = VID_W'(taken_reg);
        r_wdata = cur_reg;
        r_raddr = VID_W'(k_reg);

        case (cmd.op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    if (status.in_bad)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        new_next.slot = EIDX_W'(cnt_reg);
                        new_next.vs   = in_ch.edge_start;
                        new_next.ve   = in_ch.edge_end;
                        new_next.w    = in_ch.edge_weight;
                        j_next        = cnt_reg;
                        lastp_next    = in_ch.last_edge;
                    end
                end
            end
            OP_INS:
            begin
                // read address j-1 is driven by default
            end
            OP_INS_CMP:
            begin
                // heavier entry moves up one place
                if (status.shift)
                begin
                    s_we    = 1'b1;
                    s_wdata = s_rdata;
                    j_next  = j_reg - CNT_W'(1);
                    s_raddr = EIDX_W'(j_reg - CNT_W'(2));
                end
            end
            OP_INS_WR:
            begin
                s_we     = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_INIT:
            begin
                l_we       = 1'b1;
                v_next     = v_reg + VCNT_W'(1);
                i_next     = '0;
                taken_next = '0;
            end
            OP_K_RD:
            begin
                s_raddr = EIDX_W'(i_reg);
            end
            OP_K_GET:
            begin
                cur_next = s_rdata;
                l_raddr  = VID_W'(s_rdata.vs);
                if (status.range_bad)
                begin
                    drop_next = 1'b1;
                    i_next    = i_reg + CNT_W'(1);
                end
            end
            OP_K_LA:
            begin
                la_next = l_rdata;
                l_raddr = VID_W'(cur_reg.ve);
            end
            OP_K_LB:
            begin
                if (status.same_label)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    lb_next    = l_rdata;
                    r_we       = 1'b1;
                    taken_next = taken_reg + VCNT_W'(1);
                end
            end
            OP_WALK:
            begin
                // read vertex v while the compare of v-1 writes back
                v_next = v_reg;
                if (v_reg != nv)
                begin
                    l_raddr   = VID_W'(v_reg);
                    v_next    = v_reg + VCNT_W'(1);
                    pend_next = 1'b1;
                    pv_next   = VID_W'(v_reg);
                end
                if (pend_reg && (l_rdata == lb_reg))
                begin
                    l_we    = 1'b1;
                    l_waddr = pv_reg;
                    l_wdata = la_reg;
                end
                if (status.walk_done)
                    i_next = i_reg + CNT_W'(1);
            end
            OP_EMIT:
            begin
                k_next = '0;
                if (status.taken_zero && out_free)
                begin
                    ov_next     = 1'b1;
                    o_idx_next  = '0;
                    o_s_next    = '0;
                    o_e_next    = '0;
                    o_w_next    = '0;
                    o_last_next = 1'b1;
                    o_none_next = 1'b1;
                    o_drop_next = drop_reg;
                    cnt_next    = '0;
                    drop_next   = 1'b0;
                end
            end
            OP_E_RD:
            begin
                // taken list read address is k by default
            end
            OP_E_LD:
            begin
                ov_next     = 1'b1;
                o_idx_next  = INDEX_W'(r_rdata.slot);
                o_s_next    = r_rdata.vs;
                o_e_next    = r_rdata.ve;
                o_w_next    = r_rdata.w;
                o_last_next = status.last_out;
                o_none_next = 1'b0;
                o_drop_next = drop_reg;
                if (status.last_out)
                begin
                    cnt_next  = '0;
                    drop_next = 1'b0;
                end
                else
                begin
                    k_next = k_reg + VCNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg    <= VCOUNT_RESET;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            lastp_reg <= 1'b0;
            j_reg     <= '0;
            i_reg     <= '0;
            v_reg     <= '0;
            pend_reg  <= 1'b0;
            taken_reg <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (wr_hit)
                vc_reg <= pwdata[VCOUNT_W-1:0];
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            lastp_reg <= lastp_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            v_reg     <= v_next;
            pend_reg  <= pend_next;
            taken_reg <= taken_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        cur_reg    <= cur_next;
        la_reg     <= la_next;
        lb_reg     <= lb_next;
        pv_reg     <= pv_next;
        o_idx_reg  <= o_idx_next;
        o_s_reg    <= o_s_next;
        o_e_reg    <= o_e_next;
        o_w_reg    <= o_w_next;
        o_last_reg <= o_last_next;
        o_none_reg <= o_none_next;
        o_drop_reg <= o_drop_next;
    end

    assign in_ch.ready            = in_ready;
    assign out_ch.valid           = ov_reg;
    assign out_ch.tree_edge_index = o_idx_reg;
    assign out_ch.tree_start      = o_s_reg;
    assign out_ch.tree_end        = o_e_reg;
    assign out_ch.tree_weight     = o_w_reg;
    assign out_ch.last_result     = o_last_reg;
    assign out_ch.no_edge         = o_none_reg;
    assign out_ch.edges_dropped   = o_drop_reg;

endmodule

`default_nettype wire

// File: src/kruskal_minimum_spanning_tree_top.sv
// ============================================================================
// kruskal_minimum_spanning_tree_top - minimum spanning forest engine
// Loads weighted edges, builds the spanning forest, streams the chosen edges.
// ============================================================================
// usage:
//   in_ch carries one edge per word; last_edge marks the final edge of a graph.
//   kept edges are insertion-sorted on arrival: in_ch is busy after an accept
//   while the new edge moves past each heavier stored edge. after the last
//   edge the block sets each vertex label to its own index, then scans the
//   sorted list, with a relabel walk over the first min(vertex_count,
//   MAX_VERTICES) vertices for each taken edge.
//   the label ram port (one read, one write per cycle) sets the walk length.
//   results then leave on out_ch from a registered output stage, the next word
//   loaded once it is free; a stalled receiver simply holds that stage and
//   the block waits. a run with no taken edge gives a single no_edge word.
//   in_ready is low from the last edge until the last result is loaded.
//   the user must write vertex_count over apb at byte address 0 while idle;
//   the block does not enforce it. reset (rst_n low) empties the edge list,
//   clears the drop flag, sets vertex_count to 64; no partial graph survives.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kruskal_minimum_spanning_tree_top #(
    parameter int MAX_VERTICES = kmst_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = kmst_pkg::MAX_EDGES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    kmst_in_if.sink                              in_ch,
    kmst_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kmst_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kmst_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kmst_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import kmst_pkg::*;

    kmst_cmd_t    cmd;
    kmst_status_t status;

    kmst_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .status(status),
        .cmd(cmd)
    );

    kmst_dp #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES(MAX_EDGES)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cmd(cmd),
        .status(status)
    );

endmodule

`default_nettype wire

// File: src/kmst_checker.sv
// ============================================================================
// kmst_checker - port-level checks
// Watches the result channel of the spanning tree engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kmst_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  tree_edge_index,
    input wire logic [5:0]  tree_start,
    input wire logic [5:0]  tree_end,
    input wire logic [31:0] tree_weight,
    input wire logic        last_result,
    input wire logic        no_edge
);

    // an empty forest is reported as one closing word
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_edge |-> last_result)
        else $error("no_edge word without last_result");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_edge |-> (tree_edge_index == 8'd0) && (tree_start == 6'd0) &&
                                 (tree_end == 6'd0) && (tree_weight == 32'd0))
        else $error("no_edge word carries nonzero edge fields");

    // self-loops never join two components
    a_no_loop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !no_edge |-> tree_start != tree_end)
        else $error("self-loop emitted as tree edge");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tree_edge_index) &&
                                    $stable(tree_weight) && $stable(last_result))
        else $error("stalled result word changed");

endmodule

bind kruskal_minimum_spanning_tree_top kmst_checker u_kmst_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .tree_edge_index(out_ch.tree_edge_index),
    .tree_start(out_ch.tree_start),
    .tree_end(out_ch.tree_end),
    .tree_weight(out_ch.tree_weight),
    .last_result(out_ch.last_result),
    .no_edge(out_ch.no_edge)
);

`default_nettype wire
